>>> rtl/mlsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mlsi_pkg;

  localparam int unsigned NLANE    = 6;
  localparam int unsigned QBITS    = 34;
  localparam int unsigned SQ_STEPS = 31;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [63:0] w64_t;

  localparam w64_t MAX32 = 64'sd2147483647;
  localparam w64_t MIN32 = -64'sd2147483648;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SING = 2'd1,
    ST_NEG  = 2'd2,
    ST_SAT  = 2'd3
  } mlsi_status_e;

  typedef struct packed {
    q32_t psi_00;
    q32_t psi_01;
    q32_t psi_02;
    q32_t psi_03;
    q32_t psi_11;
    q32_t psi_12;
    q32_t psi_13;
    q32_t psi_22;
    q32_t psi_23;
    q32_t psi_33;
  } mlsi_in_t;

  typedef struct packed {
    q32_t        inv_xx;
    q32_t        inv_xy;
    q32_t        inv_xz;
    q32_t        inv_yy;
    q32_t        inv_yz;
    q32_t        inv_zz;
    q32_t        shift_x;
    q32_t        shift_y;
    q32_t        shift_z;
    logic [30:0] lapse;
    logic [1:0]  status;
  } mlsi_out_t;

  // sideband into the divider lanes
  typedef struct packed {
    q32_t             p00;
    q32_t             p01;
    q32_t             p02;
    q32_t             p03;
    logic             cof_ov;
    logic             sing;
    logic [NLANE-1:0] neg;
    logic [NLANE-1:0] dovf;
  } mlsi_dside_t;

  typedef struct packed {
    q32_t p00;
    q32_t p01;
    q32_t p02;
    q32_t p03;
    logic ov;
    logic sing;
  } mlsi_rside_t;

  typedef struct packed {
    q32_t [NLANE-1:0] inv;
    q32_t [2:0]       sh;
    logic             ov;
    logic             sing;
  } mlsi_sside_t;

  function automatic w64_t mul(input q32_t a, input q32_t b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [63:0] mag(input w64_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // round to fb fraction bits, half away from zero
  function automatic w64_t rnd(input w64_t v, input int unsigned fb);
    logic [63:0] m;
    m = (mag(v) + (64'd1 << (fb - 1))) >> fb;
    return v[63] ? -w64_t'(m) : w64_t'(m);
  endfunction

  function automatic q32_t sat32(input w64_t v);
    if (v > MAX32) return q32_t'(MAX32[31:0]);
    if (v < MIN32) return q32_t'(MIN32[31:0]);
    return q32_t'(v[31:0]);
  endfunction

  function automatic logic ovf32(input w64_t v);
    return (v > MAX32) || (v < MIN32);
  endfunction

endpackage
`default_nettype wire

>>> rtl/metric_to_lapse_shift_inverse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// done_o strobes once a taken word has passed the cofdet, div, raise and sqrt pipelines in turn.
// Throughput: one word per cycle; busy_o stays low, every start is taken.
// The divider lanes (34 stages, one quotient bit each) and the root (31 stages) set the depth.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears the valid bits only; data registers are not reset.
module metric_to_lapse_shift_inverse_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire mlsi_pkg::mlsi_in_t   psi_i,
  output logic                      done_o,
  output mlsi_pkg::mlsi_out_t       res_o
);

  logic                                      cd_valid;
  logic [mlsi_pkg::NLANE-1:0][63:0]          cd_n;
  logic [63:0]                               cd_d;
  mlsi_pkg::mlsi_dside_t                     cd_side;
  logic                                      dv_valid;
  mlsi_pkg::q32_t [mlsi_pkg::NLANE-1:0]      dv_inv;
  mlsi_pkg::mlsi_rside_t                     dv_side;
  logic                                      rs_valid;
  mlsi_pkg::w64_t                            rs_lsq;
  mlsi_pkg::mlsi_sside_t                     rs_side;

  assign busy_o = 1'b0;

  mlsi_cofdet #(.FRAC_BITS(FRAC_BITS)) u_cofdet (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .psi_i   (psi_i),
    .valid_o (cd_valid),
    .n_o     (cd_n),
    .d_o     (cd_d),
    .side_o  (cd_side)
  );

  mlsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cd_valid),
    .n_i     (cd_n),
    .d_i     (cd_d),
    .side_i  (cd_side),
    .valid_o (dv_valid),
    .inv_o   (dv_inv),
    .side_o  (dv_side)
  );

  mlsi_raise #(.FRAC_BITS(FRAC_BITS)) u_raise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .inv_i   (dv_inv),
    .side_i  (dv_side),
    .valid_o (rs_valid),
    .lsq_o   (rs_lsq),
    .side_o  (rs_side)
  );

  mlsi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rs_valid),
    .lsq_i   (rs_lsq),
    .side_i  (rs_side),
    .valid_o (done_o),
    .res_o   (res_o)
  );

`ifndef SYNTH
  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == mlsi_pkg::ST_SING |->
      res_o.lapse == '0 && res_o.inv_xx == '0 && res_o.shift_x == '0 && res_o.inv_zz == '0)
    else $error("singular word carries nonzero data");

  a_neg_lapse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == mlsi_pkg::ST_NEG |-> res_o.lapse == '0)
    else $error("negative lapse square with nonzero lapse");

  a_no_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_valid |-> $past(start_i, 4) && !$past(busy_o, 4))
    else $error("pipeline word without a start");
`endif

endmodule
`default_nettype wire

>>> rtl/mlsi_cofdet.sv
`timescale 1ns / 1ps
`default_nettype none
module mlsi_cofdet #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  input  wire mlsi_pkg::mlsi_in_t                     psi_i,
  output logic                                        valid_o,
  output logic [mlsi_pkg::NLANE-1:0][63:0]            n_o,
  output logic [63:0]                                 d_o,
  output mlsi_pkg::mlsi_dside_t                       side_o
);

  // stage 1: cofactor products
  logic               v1_q;
  mlsi_pkg::w64_t     prod_d [12];
  mlsi_pkg::w64_t     prod_q [12];
  mlsi_pkg::mlsi_in_t in1_q;

  always_comb begin
    prod_d[0]  = mlsi_pkg::mul(psi_i.psi_22, psi_i.psi_33);
    prod_d[1]  = mlsi_pkg::mul(psi_i.psi_23, psi_i.psi_23);
    prod_d[2]  = mlsi_pkg::mul(psi_i.psi_13, psi_i.psi_23);
    prod_d[3]  = mlsi_pkg::mul(psi_i.psi_12, psi_i.psi_33);
    prod_d[4]  = mlsi_pkg::mul(psi_i.psi_12, psi_i.psi_23);
    prod_d[5]  = mlsi_pkg::mul(psi_i.psi_13, psi_i.psi_22);
    prod_d[6]  = mlsi_pkg::mul(psi_i.psi_11, psi_i.psi_33);
    prod_d[7]  = mlsi_pkg::mul(psi_i.psi_13, psi_i.psi_13);
    prod_d[8]  = mlsi_pkg::mul(psi_i.psi_12, psi_i.psi_13);
    prod_d[9]  = mlsi_pkg::mul(psi_i.psi_11, psi_i.psi_23);
    prod_d[10] = mlsi_pkg::mul(psi_i.psi_11, psi_i.psi_22);
    prod_d[11] = mlsi_pkg::mul(psi_i.psi_12, psi_i.psi_12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    in1_q  <= psi_i;
  end

  // stage 2: round, subtract, saturate
  logic               v2_q;
  mlsi_pkg::q32_t     cof_d [mlsi_pkg::NLANE];
  mlsi_pkg::q32_t     cof_q [mlsi_pkg::NLANE];
  logic               ov2_d, ov2_q;
  mlsi_pkg::mlsi_in_t in2_q;

  always_comb begin
    mlsi_pkg::w64_t diff;
    ov2_d = 1'b0;
    for (int k = 0; k < mlsi_pkg::NLANE; k++) begin
      diff = mlsi_pkg::rnd(prod_q[2*k], FRAC_BITS) - mlsi_pkg::rnd(prod_q[2*k+1], FRAC_BITS);
      cof_d[k] = mlsi_pkg::sat32(diff);
      ov2_d    = ov2_d | mlsi_pkg::ovf32(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cof_q <= cof_d;
    ov2_q <= ov2_d;
    in2_q <= in1_q;
  end

  // stage 3: determinant products
  logic               v3_q;
  mlsi_pkg::w64_t     dp_d [3];
  mlsi_pkg::w64_t     dp_q [3];
  mlsi_pkg::q32_t     cof3_q [mlsi_pkg::NLANE];
  logic               ov3_q;
  mlsi_pkg::mlsi_in_t in3_q;

  always_comb begin
    dp_d[0] = mlsi_pkg::mul(in2_q.psi_11, cof_q[0]);
    dp_d[1] = mlsi_pkg::mul(in2_q.psi_12, cof_q[1]);
    dp_d[2] = mlsi_pkg::mul(in2_q.psi_13, cof_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q   <= dp_d;
    cof3_q <= cof_q;
    ov3_q  <= ov2_q;
    in3_q  <= in2_q;
  end

  // stage 4: determinant, divider operands
  logic                                 v4_q;
  logic [mlsi_pkg::NLANE-1:0][63:0]     n_d, n_q;
  logic [63:0]                          dm_d, dm_q;
  mlsi_pkg::mlsi_dside_t                side_d, side_q;

  always_comb begin
    mlsi_pkg::w64_t det;
    det  = mlsi_pkg::rnd(dp_q[0], FRAC_BITS) + mlsi_pkg::rnd(dp_q[1], FRAC_BITS)
         + mlsi_pkg::rnd(dp_q[2], FRAC_BITS);
    dm_d = mlsi_pkg::mag(det);
    side_d.p00    = in3_q.psi_00;
    side_d.p01    = in3_q.psi_01;
    side_d.p02    = in3_q.psi_02;
    side_d.p03    = in3_q.psi_03;
    side_d.cof_ov = ov3_q;
    side_d.sing   = (det == '0);
    for (int k = 0; k < mlsi_pkg::NLANE; k++) begin
      n_d[k] = (mlsi_pkg::mag(64'(cof3_q[k])) << FRAC_BITS) + (dm_d >> 1);
      side_d.neg[k]  = cof3_q[k][31] ^ det[63];
      side_d.dovf[k] = (n_d[k] >> mlsi_pkg::QBITS) >= dm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    dm_q   <= dm_d;
    side_q <= side_d;
  end

  assign valid_o = v4_q;
  assign n_o     = n_q;
  assign d_o     = dm_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

>>> rtl/mlsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mlsi_div (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  input  wire logic [mlsi_pkg::NLANE-1:0][63:0]       n_i,
  input  wire logic [63:0]                            d_i,
  input  wire mlsi_pkg::mlsi_dside_t                  side_i,
  output logic                                        valid_o,
  output mlsi_pkg::q32_t [mlsi_pkg::NLANE-1:0]        inv_o,
  output mlsi_pkg::mlsi_rside_t                       side_o
);

  localparam int unsigned QB = mlsi_pkg::QBITS;
  localparam int unsigned NL = mlsi_pkg::NLANE;

  logic                        v_q [QB];
  logic [NL-1:0][63:0]         r_q [QB];
  logic [NL-1:0][63:0]         n_q [QB];
  logic [NL-1:0][QB-1:0]       q_q [QB];
  logic [63:0]                 d_q [QB];
  mlsi_pkg::mlsi_dside_t       s_q [QB];

  // one quotient bit per stage in each lane, divisor shared
  for (genvar j = 0; j < QB; j++) begin : g_st
    logic                  v_src;
    logic [NL-1:0][63:0]   r_src, n_src, r_nxt;
    logic [NL-1:0][QB-1:0] q_src, q_nxt;
    logic [63:0]           d_src;
    mlsi_pkg::mlsi_dside_t s_src;

    if (j == 0) begin : g_in
      always_comb begin
        v_src = valid_i;
        n_src = n_i;
        d_src = d_i;
        s_src = side_i;
        q_src = '0;
        for (int k = 0; k < NL; k++) begin
          r_src[k] = n_i[k] >> QB;
        end
      end
    end else begin : g_mid
      always_comb begin
        v_src = v_q[j-1];
        n_src = n_q[j-1];
        d_src = d_q[j-1];
        s_src = s_q[j-1];
        q_src = q_q[j-1];
        r_src = r_q[j-1];
      end
    end

    always_comb begin
      logic [63:0] rn;
      logic        ge;
      for (int k = 0; k < NL; k++) begin
        rn       = {r_src[k][62:0], n_src[k][QB-1-j]};
        ge       = rn >= d_src;
        r_nxt[k] = ge ? rn - d_src : rn;
        q_nxt[k] = {q_src[k][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[j] <= r_nxt;
      n_q[j] <= n_src;
      q_q[j] <= q_nxt;
      d_q[j] <= d_src;
      s_q[j] <= s_src;
    end
  end

  // sign and saturation
  logic                          vo_q;
  mlsi_pkg::q32_t [NL-1:0]       inv_d, inv_q;
  mlsi_pkg::mlsi_rside_t         so_d, so_q;

  always_comb begin
    logic [QB-1:0]         q;
    logic                  sat;
    mlsi_pkg::mlsi_dside_t s;
    s        = s_q[QB-1];
    so_d.p00 = s.p00;
    so_d.p01 = s.p01;
    so_d.p02 = s.p02;
    so_d.p03 = s.p03;
    so_d.sing = s.sing;
    so_d.ov   = s.cof_ov;
    for (int k = 0; k < NL; k++) begin
      q = q_q[QB-1][k];
      if (s.neg[k]) begin
        sat      = s.dovf[k] || (q > QB'(64'h8000_0000));
        inv_d[k] = sat ? mlsi_pkg::q32_t'(mlsi_pkg::MIN32[31:0]) : mlsi_pkg::q32_t'(-q[31:0]);
      end else begin
        sat      = s.dovf[k] || (q > QB'(64'h7FFF_FFFF));
        inv_d[k] = sat ? mlsi_pkg::q32_t'(mlsi_pkg::MAX32[31:0]) : mlsi_pkg::q32_t'(q[31:0]);
      end
      so_d.ov = so_d.ov | sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q <= inv_d;
    so_q  <= so_d;
  end

  assign valid_o = vo_q;
  assign inv_o   = inv_q;
  assign side_o  = so_q;

endmodule
`default_nettype wire

>>> rtl/mlsi_raise.sv
`timescale 1ns / 1ps
`default_nettype none
module mlsi_raise #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  input  wire mlsi_pkg::q32_t [mlsi_pkg::NLANE-1:0]   inv_i,
  input  wire mlsi_pkg::mlsi_rside_t                  side_i,
  output logic                                        valid_o,
  output mlsi_pkg::w64_t                              lsq_o,
  output mlsi_pkg::mlsi_sside_t                       side_o
);

  localparam int unsigned NL = mlsi_pkg::NLANE;

  // stage 1: shift products
  logic                         v1_q;
  mlsi_pkg::w64_t               sp_d [9];
  mlsi_pkg::w64_t               sp_q [9];
  mlsi_pkg::q32_t [NL-1:0]      inv1_q;
  mlsi_pkg::mlsi_rside_t        s1_q;

  always_comb begin
    sp_d[0] = mlsi_pkg::mul(inv_i[0], side_i.p01);
    sp_d[1] = mlsi_pkg::mul(inv_i[1], side_i.p02);
    sp_d[2] = mlsi_pkg::mul(inv_i[2], side_i.p03);
    sp_d[3] = mlsi_pkg::mul(inv_i[1], side_i.p01);
    sp_d[4] = mlsi_pkg::mul(inv_i[3], side_i.p02);
    sp_d[5] = mlsi_pkg::mul(inv_i[4], side_i.p03);
    sp_d[6] = mlsi_pkg::mul(inv_i[2], side_i.p01);
    sp_d[7] = mlsi_pkg::mul(inv_i[4], side_i.p02);
    sp_d[8] = mlsi_pkg::mul(inv_i[5], side_i.p03);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q   <= sp_d;
    inv1_q <= inv_i;
    s1_q   <= side_i;
  end

  // stage 2: raised shift sums
  logic                     v2_q;
  mlsi_pkg::q32_t [2:0]     sh_d, sh_q;
  logic                     ov2_d, ov2_q;
  mlsi_pkg::q32_t [NL-1:0]  inv2_q;
  mlsi_pkg::mlsi_rside_t    s2_q;

  always_comb begin
    mlsi_pkg::w64_t sum;
    ov2_d = s1_q.ov;
    for (int k = 0; k < 3; k++) begin
      sum = mlsi_pkg::rnd(sp_q[3*k], FRAC_BITS) + mlsi_pkg::rnd(sp_q[3*k+1], FRAC_BITS)
          + mlsi_pkg::rnd(sp_q[3*k+2], FRAC_BITS);
      sh_d[k] = mlsi_pkg::sat32(sum);
      ov2_d   = ov2_d | mlsi_pkg::ovf32(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    ov2_q  <= ov2_d;
    inv2_q <= inv1_q;
    s2_q   <= s1_q;
  end

  // stage 3: lapse square products
  logic                   v3_q;
  mlsi_pkg::w64_t         lp_d [3];
  mlsi_pkg::w64_t         lp_q [3];
  mlsi_pkg::mlsi_sside_t  ss3_q;
  mlsi_pkg::q32_t         p00_3_q;

  always_comb begin
    lp_d[0] = mlsi_pkg::mul(sh_q[0], s2_q.p01);
    lp_d[1] = mlsi_pkg::mul(sh_q[1], s2_q.p02);
    lp_d[2] = mlsi_pkg::mul(sh_q[2], s2_q.p03);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lp_q       <= lp_d;
    ss3_q.inv  <= inv2_q;
    ss3_q.sh   <= sh_q;
    ss3_q.ov   <= ov2_q;
    ss3_q.sing <= s2_q.sing;
    p00_3_q    <= s2_q.p00;
  end

  // stage 4: lapse square
  logic                  v4_q;
  mlsi_pkg::w64_t        lsq_d, lsq_q;
  mlsi_pkg::mlsi_sside_t ss4_q;

  assign lsq_d = -64'(p00_3_q) + mlsi_pkg::rnd(lp_q[0], FRAC_BITS)
               + mlsi_pkg::rnd(lp_q[1], FRAC_BITS) + mlsi_pkg::rnd(lp_q[2], FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lsq_q <= lsq_d;
    ss4_q <= ss3_q;
  end

  assign valid_o = v4_q;
  assign lsq_o   = lsq_q;
  assign side_o  = ss4_q;

endmodule
`default_nettype wire

>>> rtl/mlsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module mlsi_sqrt #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire mlsi_pkg::w64_t         lsq_i,
  input  wire mlsi_pkg::mlsi_sside_t  side_i,
  output logic                        valid_o,
  output mlsi_pkg::mlsi_out_t         res_o
);

  localparam int unsigned NS = mlsi_pkg::SQ_STEPS;

  // entry: range check and scale
  logic                  ve_q;
  logic [63:0]           xe_q;
  logic                  neg_e_q, big_e_q;
  mlsi_pkg::mlsi_sside_t se_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xe_q    <= 64'(lsq_i) << FRAC_BITS;
    neg_e_q <= lsq_i[63];
    big_e_q <= !lsq_i[63] && (64'(lsq_i) >= (64'd1 << (62 - FRAC_BITS)));
    se_q    <= side_i;
  end

  logic                  v_q   [NS];
  logic [63:0]           x_q   [NS];
  logic [63:0]           r_q   [NS];
  logic                  neg_q [NS];
  logic                  big_q [NS];
  mlsi_pkg::mlsi_sside_t s_q   [NS];

  // one root bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (2 * (NS - 1 - j));
    logic                  v_src, neg_src, big_src;
    logic [63:0]           x_src, r_src, x_nxt, r_nxt;
    mlsi_pkg::mlsi_sside_t s_src;

    if (j == 0) begin : g_in
      always_comb begin
        v_src   = ve_q;
        x_src   = xe_q;
        r_src   = '0;
        neg_src = neg_e_q;
        big_src = big_e_q;
        s_src   = se_q;
      end
    end else begin : g_mid
      always_comb begin
        v_src   = v_q[j-1];
        x_src   = x_q[j-1];
        r_src   = r_q[j-1];
        neg_src = neg_q[j-1];
        big_src = big_q[j-1];
        s_src   = s_q[j-1];
      end
    end

    always_comb begin
      if (x_src >= r_src + BIT) begin
        x_nxt = x_src - (r_src + BIT);
        r_nxt = (r_src >> 1) + BIT;
      end else begin
        x_nxt = x_src;
        r_nxt = r_src >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[j]   <= x_nxt;
      r_q[j]   <= r_nxt;
      neg_q[j] <= neg_src;
      big_q[j] <= big_src;
      s_q[j]   <= s_src;
    end
  end

  // assemble the result word
  logic                vo_q;
  mlsi_pkg::mlsi_out_t res_d, res_q;

  always_comb begin
    mlsi_pkg::mlsi_sside_t s;
    s = s_q[NS-1];
    res_d.inv_xx  = s.inv[0];
    res_d.inv_xy  = s.inv[1];
    res_d.inv_xz  = s.inv[2];
    res_d.inv_yy  = s.inv[3];
    res_d.inv_yz  = s.inv[4];
    res_d.inv_zz  = s.inv[5];
    res_d.shift_x = s.sh[0];
    res_d.shift_y = s.sh[1];
    res_d.shift_z = s.sh[2];
    if (neg_q[NS-1]) begin
      res_d.lapse  = '0;
      res_d.status = mlsi_pkg::ST_NEG;
    end else begin
      res_d.lapse  = big_q[NS-1] ? 31'h7FFF_FFFF : r_q[NS-1][30:0];
      res_d.status = (s.ov || big_q[NS-1]) ? mlsi_pkg::ST_SAT : mlsi_pkg::ST_OK;
    end
    if (s.sing) begin
      res_d        = '0;
      res_d.status = mlsi_pkg::ST_SING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire
